### rtl/core/key_repeat_level_control_assert.svh
// ----------------------------------------------------------------------------
// key_repeat_level_control_assert.svh
// Assertion macros shared by the checkers of the key repeat level control.
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef KEY_REPEAT_LEVEL_CONTROL_ASSERT_SVH
`define KEY_REPEAT_LEVEL_CONTROL_ASSERT_SVH

// same-cycle implication
`define KRL_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key repeat level control check failed");

// next-cycle implication
`define KRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key repeat level control check failed");

`endif

### rtl/core/krl_pkg.sv
// ----------------------------------------------------------------------------
// krl_pkg
// Types and constants of the key repeat level control.
// ----------------------------------------------------------------------------
package krl_pkg;

    // item kinds
    localparam logic [1:0] KIND_WAKE_START = 2'd0;
    localparam logic [1:0] KIND_EVENT      = 2'd1;
    localparam logic [1:0] KIND_WAKE_END   = 2'd2;

    // event classes and codes
    localparam logic [15:0] EVT_KEY     = 16'd1;
    localparam logic [15:0] EVT_SWITCH  = 16'd5;
    localparam logic [9:0]  KEY_MENU_A  = 10'd314;
    localparam logic [9:0]  KEY_MENU_B  = 10'd315;
    localparam logic [9:0]  KEY_MENU_C  = 10'd316;
    localparam logic [9:0]  KEY_PLUS    = 10'd115;
    localparam logic [9:0]  KEY_MINUS   = 10'd114;
    localparam logic [9:0]  SWITCH_MUTE = 10'd1;
    localparam logic [9:0]  SWITCH_JACK = 10'd2;
    localparam logic [7:0]  KEY_VAL_MAX = 8'd2;

    localparam logic [6:0]  WAKE_CAP_MS = 7'd100;

    // register indexes
    localparam logic [2:0] REG_HOLD_DELAY      = 3'd0;
    localparam logic [2:0] REG_REPEAT_INTERVAL = 3'd1;
    localparam logic [2:0] REG_STALE_LIMIT     = 3'd2;
    localparam logic [2:0] REG_VOL_LIMIT       = 3'd3;
    localparam logic [2:0] REG_BRI_LIMIT       = 3'd4;
    localparam logic [2:0] REG_VOLUME_START    = 3'd5;
    localparam logic [2:0] REG_BRIGHTNESS_START = 3'd6;

    // register reset values
    localparam logic [15:0] HOLD_DELAY_RST      = 16'd300;
    localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd100;
    localparam logic [15:0] STALE_LIMIT_RST     = 16'd1000;
    localparam logic [4:0]  VOL_LIMIT_RST       = 5'd20;
    localparam logic [3:0]  BRI_LIMIT_RST       = 4'd10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic [15:0] event_type;
        logic [9:0]  event_code;
        logic [7:0]  event_value;
        logic [31:0] event_ms;
    } krl_in_t;

    typedef struct packed {
        logic [4:0] volume;
        logic [3:0] brightness;
        logic       mute;
        logic       jack;
        logic       repeat_armed;
        logic [6:0] wake_in_ms;
    } krl_out_t;

    // classified command handed from front to back
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_WAKE_END,
        OP_MENU,
        OP_PLUS,
        OP_MINUS,
        OP_MUTE,
        OP_JACK
    } krl_op_t;

    typedef struct packed {
        krl_op_t     op;
        logic        on;
        logic [31:0] deadline;
        logic [31:0] wake_time;
    } krl_cmd_t;

    typedef struct packed {
        logic [15:0] hold_delay;
        logic [15:0] repeat_interval;
        logic [15:0] stale_limit;
        logic [4:0]  vol_limit;
        logic [3:0]  bri_limit;
    } krl_cfg_t;

    typedef struct packed {
        logic       vol_load;
        logic       bri_load;
        logic [4:0] vol_val;
        logic [3:0] bri_val;
    } krl_load_t;

    // state after one item, ahead of the wake delay math
    typedef struct packed {
        logic [4:0]  volume;
        logic [3:0]  brightness;
        logic        mute;
        logic        jack;
        logic        plus_held;
        logic        minus_held;
        logic [31:0] plus_deadline;
        logic [31:0] minus_deadline;
        logic [31:0] wake_time;
    } krl_snap_t;

endpackage

### rtl/core/krl_front.sv
// ----------------------------------------------------------------------------
// krl_front
// Accepts input words, tracks wake times, drops stale events and classifies
// each word into a command for the back end.
// ----------------------------------------------------------------------------
module krl_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  krl_pkg::krl_in_t   in_item,
    input  krl_pkg::krl_cfg_t  cfg,
    input  logic               queue_full,
    output logic               push,
    output krl_pkg::krl_cmd_t  cmd
);
    import krl_pkg::*;

    logic [31:0] wake_reg;
    logic [31:0] wake_next;
    logic [31:0] last_wake_reg;
    logic [31:0] last_wake_next;
    logic [31:0] gap;
    logic [31:0] age;
    logic        stale_gap;
    logic        stale_evt;
    logic        on;

    assign in_ready  = !queue_full;
    assign push      = in_valid && in_ready;
    assign gap       = in_item.now_ms - last_wake_reg;
    assign age       = wake_reg - in_item.event_ms;
    assign stale_gap = gap > {16'd0, cfg.stale_limit};
    assign stale_evt = age > {16'd0, cfg.stale_limit};
    assign on        = in_item.event_value != 8'd0;

    always_comb
    begin
        wake_next      = wake_reg;
        last_wake_next = last_wake_reg;
        cmd.op         = OP_NONE;
        cmd.on         = on;
        cmd.deadline   = wake_reg + {16'd0, cfg.hold_delay};
        unique case (in_item.kind)
            KIND_WAKE_START:
            begin
                wake_next = in_item.now_ms;
                if (stale_gap)
                begin
                    cmd.op = OP_CLEAR;
                end
            end
            KIND_EVENT:
            begin
                if (!stale_evt)
                begin
                    if (in_item.event_type == EVT_SWITCH)
                    begin
                        if (in_item.event_code == SWITCH_JACK)
                        begin
                            cmd.op = OP_JACK;
                        end
                        else if (in_item.event_code == SWITCH_MUTE)
                        begin
                            cmd.op = OP_MUTE;
                        end
                    end
                    else if (in_item.event_type == EVT_KEY &&
                             in_item.event_value <= KEY_VAL_MAX)
                    begin
                        if (in_item.event_code == KEY_MENU_A ||
                            in_item.event_code == KEY_MENU_B ||
                            in_item.event_code == KEY_MENU_C)
                        begin
                            cmd.op = OP_MENU;
                        end
                        else if (in_item.event_code == KEY_PLUS)
                        begin
                            cmd.op = OP_PLUS;
                        end
                        else if (in_item.event_code == KEY_MINUS)
                        begin
                            cmd.op = OP_MINUS;
                        end
                    end
                end
            end
            KIND_WAKE_END:
            begin
                cmd.op         = OP_WAKE_END;
                last_wake_next = wake_reg;
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
        cmd.wake_time = wake_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_reg      <= '0;
            last_wake_reg <= '0;
        end
        else if (push)
        begin
            wake_reg      <= wake_next;
            last_wake_reg <= last_wake_next;
        end
    end

endmodule

### rtl/core/krl_queue.sv
// ----------------------------------------------------------------------------
// krl_queue
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module krl_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  krl_pkg::krl_cmd_t  push_data,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output krl_pkg::krl_cmd_t  pop_data
);
    import krl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    krl_cmd_t        entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full     = count_reg == CW'(DEPTH);
    assign valid    = count_reg != '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/krl_exec.sv
// ----------------------------------------------------------------------------
// krl_exec
// Back end: holds key and level state, applies one command per cycle while no
// stalled snapshot blocks it, and registers a snapshot of the resulting state.
// ----------------------------------------------------------------------------
module krl_exec
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  krl_pkg::krl_cmd_t  cmd,
    output logic               pop,
    input  krl_pkg::krl_cfg_t  cfg,
    input  krl_pkg::krl_load_t load,
    output logic               snap_valid,
    output krl_pkg::krl_snap_t snap,
    input  logic               snap_ready
);
    import krl_pkg::*;

    logic        menu_reg,        menu_next;
    logic        plus_held_reg,   plus_held_next;
    logic        plus_fresh_reg,  plus_fresh_next;
    logic [31:0] plus_dl_reg,     plus_dl_next;
    logic        minus_held_reg,  minus_held_next;
    logic        minus_fresh_reg, minus_fresh_next;
    logic [31:0] minus_dl_reg,    minus_dl_next;
    logic [4:0]  vol_reg,         vol_next;
    logic [3:0]  bri_reg,         bri_next;
    logic        mute_reg,        mute_next;
    logic        jack_reg,        jack_next;
    logic        snap_valid_reg,  snap_valid_next;
    krl_snap_t   snap_reg,        snap_next;

    logic        plus_go;
    logic        minus_go;
    logic [4:0]  vol_up;
    logic [4:0]  vol_dn;
    logic [3:0]  bri_up;
    logic [3:0]  bri_dn;

    assign pop        = cmd_valid && (!snap_valid_reg || snap_ready);
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    assign plus_go  = plus_fresh_reg ||
                      (plus_held_reg && cmd.wake_time >= plus_dl_reg);
    assign minus_go = minus_fresh_reg ||
                      (minus_held_reg && cmd.wake_time >= minus_dl_reg);

    // plus steps first, then minus, both saturating
    assign vol_up = (plus_go && vol_reg < cfg.vol_limit) ? vol_reg + 5'd1 : vol_reg;
    assign vol_dn = (minus_go && vol_up != 5'd0) ? vol_up - 5'd1 : vol_up;
    assign bri_up = (plus_go && bri_reg < cfg.bri_limit) ? bri_reg + 4'd1 : bri_reg;
    assign bri_dn = (minus_go && bri_up != 4'd0) ? bri_up - 4'd1 : bri_up;

    always_comb
    begin
        menu_next        = menu_reg;
        plus_held_next   = plus_held_reg;
        plus_fresh_next  = plus_fresh_reg;
        plus_dl_next     = plus_dl_reg;
        minus_held_next  = minus_held_reg;
        minus_fresh_next = minus_fresh_reg;
        minus_dl_next    = minus_dl_reg;
        vol_next         = vol_reg;
        bri_next         = bri_reg;
        mute_next        = mute_reg;
        jack_next        = jack_reg;
        if (pop)
        begin
            unique case (cmd.op)
                OP_NONE:
                begin
                end
                OP_CLEAR:
                begin
                    menu_next        = 1'b0;
                    plus_held_next   = 1'b0;
                    plus_fresh_next  = 1'b0;
                    plus_dl_next     = '0;
                    minus_held_next  = 1'b0;
                    minus_fresh_next = 1'b0;
                    minus_dl_next    = '0;
                end
                OP_WAKE_END:
                begin
                    if (plus_go)
                    begin
                        if (plus_fresh_reg)
                        begin
                            plus_fresh_next = 1'b0;
                        end
                        else
                        begin
                            plus_dl_next = plus_dl_reg + {16'd0, cfg.repeat_interval};
                        end
                    end
                    if (minus_go)
                    begin
                        if (minus_fresh_reg)
                        begin
                            minus_fresh_next = 1'b0;
                        end
                        else
                        begin
                            minus_dl_next = minus_dl_reg + {16'd0, cfg.repeat_interval};
                        end
                    end
                    if (menu_reg)
                    begin
                        bri_next = bri_dn;
                    end
                    else
                    begin
                        vol_next = vol_dn;
                    end
                end
                OP_MENU:
                begin
                    menu_next = cmd.on;
                end
                OP_PLUS:
                begin
                    plus_held_next  = cmd.on;
                    plus_fresh_next = cmd.on;
                    if (cmd.on)
                    begin
                        plus_dl_next = cmd.deadline;
                    end
                end
                OP_MINUS:
                begin
                    minus_held_next  = cmd.on;
                    minus_fresh_next = cmd.on;
                    if (cmd.on)
                    begin
                        minus_dl_next = cmd.deadline;
                    end
                end
                OP_MUTE:
                begin
                    mute_next = cmd.on;
                end
                OP_JACK:
                begin
                    jack_next = cmd.on;
                end
                default:
                begin
                end
            endcase
        end
        if (load.vol_load)
        begin
            vol_next = load.vol_val;
        end
        if (load.bri_load)
        begin
            bri_next = load.bri_val;
        end

        snap_valid_next = pop || (snap_valid_reg && !snap_ready);
        snap_next       = snap_reg;
        if (pop)
        begin
            snap_next.volume         = vol_next;
            snap_next.brightness     = bri_next;
            snap_next.mute           = mute_next;
            snap_next.jack           = jack_next;
            snap_next.plus_held      = plus_held_next;
            snap_next.minus_held     = minus_held_next;
            snap_next.plus_deadline  = plus_dl_next;
            snap_next.minus_deadline = minus_dl_next;
            snap_next.wake_time      = cmd.wake_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            menu_reg        <= 1'b0;
            plus_held_reg   <= 1'b0;
            plus_fresh_reg  <= 1'b0;
            plus_dl_reg     <= '0;
            minus_held_reg  <= 1'b0;
            minus_fresh_reg <= 1'b0;
            minus_dl_reg    <= '0;
            vol_reg         <= '0;
            bri_reg         <= '0;
            mute_reg        <= 1'b0;
            jack_reg        <= 1'b0;
            snap_valid_reg  <= 1'b0;
        end
        else
        begin
            menu_reg        <= menu_next;
            plus_held_reg   <= plus_held_next;
            plus_fresh_reg  <= plus_fresh_next;
            plus_dl_reg     <= plus_dl_next;
            minus_held_reg  <= minus_held_next;
            minus_fresh_reg <= minus_fresh_next;
            minus_dl_reg    <= minus_dl_next;
            vol_reg         <= vol_next;
            bri_reg         <= bri_next;
            mute_reg        <= mute_next;
            jack_reg        <= jack_next;
            snap_valid_reg  <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

endmodule

### rtl/core/krl_report.sv
// ----------------------------------------------------------------------------
// krl_report
// Turns a state snapshot into a result word: per-key wake delays in one
// stage, then the earliest held-key delay, or zero, into the output register.
// ----------------------------------------------------------------------------
module krl_report
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               snap_valid,
    input  krl_pkg::krl_snap_t snap,
    output logic               snap_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output krl_pkg::krl_out_t  out_item
);
    import krl_pkg::*;

    typedef struct packed {
        logic [4:0] volume;
        logic [3:0] brightness;
        logic       mute;
        logic       jack;
        logic       plus_held;
        logic       minus_held;
        logic [6:0] plus_wait;
        logic [6:0] minus_wait;
    } stage_t;

    logic        stage_valid_reg, stage_valid_next;
    stage_t      stage_reg,       stage_next;
    logic        out_valid_reg,   out_valid_next;
    krl_out_t    out_reg,         out_next;

    logic        out_free;
    logic        stage_free;
    logic [32:0] plus_diff;
    logic [32:0] minus_diff;
    logic [6:0]  wait_min;

    assign out_free   = !out_valid_reg || out_ready;
    assign stage_free = !stage_valid_reg || out_free;
    assign snap_ready = stage_free;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_reg;

    // borrow means deadline already passed
    assign plus_diff  = {1'b0, snap.plus_deadline} - {1'b0, snap.wake_time};
    assign minus_diff = {1'b0, snap.minus_deadline} - {1'b0, snap.wake_time};

    always_comb
    begin
        stage_next            = stage_reg;
        stage_valid_next      = (snap_valid && stage_free) || (stage_valid_reg && !out_free);
        if (snap_valid && stage_free)
        begin
            stage_next.volume     = snap.volume;
            stage_next.brightness = snap.brightness;
            stage_next.mute       = snap.mute;
            stage_next.jack       = snap.jack;
            stage_next.plus_held  = snap.plus_held;
            stage_next.minus_held = snap.minus_held;
            if (plus_diff[32])
            begin
                stage_next.plus_wait = 7'd0;
            end
            else if (plus_diff[31:0] > {25'd0, WAKE_CAP_MS})
            begin
                stage_next.plus_wait = WAKE_CAP_MS;
            end
            else
            begin
                stage_next.plus_wait = plus_diff[6:0];
            end
            if (minus_diff[32])
            begin
                stage_next.minus_wait = 7'd0;
            end
            else if (minus_diff[31:0] > {25'd0, WAKE_CAP_MS})
            begin
                stage_next.minus_wait = WAKE_CAP_MS;
            end
            else
            begin
                stage_next.minus_wait = minus_diff[6:0];
            end
        end
    end

    assign wait_min = (stage_reg.minus_wait < stage_reg.plus_wait) ?
                      stage_reg.minus_wait : stage_reg.plus_wait;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = (stage_valid_reg && out_free) || (out_valid_reg && !out_ready);
        if (stage_valid_reg && out_free)
        begin
            out_next.volume       = stage_reg.volume;
            out_next.brightness   = stage_reg.brightness;
            out_next.mute         = stage_reg.mute;
            out_next.jack         = stage_reg.jack;
            out_next.repeat_armed = stage_reg.plus_held || stage_reg.minus_held;
            priority if (stage_reg.plus_held && stage_reg.minus_held)
            begin
                out_next.wake_in_ms = wait_min;
            end
            else if (stage_reg.plus_held)
            begin
                out_next.wake_in_ms = stage_reg.plus_wait;
            end
            else if (stage_reg.minus_held)
            begin
                out_next.wake_in_ms = stage_reg.minus_wait;
            end
            else
            begin
                out_next.wake_in_ms = 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
        out_reg   <= out_next;
    end

endmodule

### rtl/core/key_repeat_level_control.sv
// ----------------------------------------------------------------------------
// key_repeat_level_control
// Key autorepeat volume and brightness control with an APB register port.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_item) takes wake-start, key/switch event
// and wake-end words; every accepted word yields exactly one result word on
// the output channel (out_valid/out_ready/out_item), in order.
// Throughput is one word per cycle while the output is not stalled. The front
// end classifies a word in the cycle it is accepted and writes it to a small
// command queue; the back end applies one command per cycle while its snapshot
// can move on, and two report stages compute the wake delay. When out_ready is
// low, results stay in the output register, the report stages and the queue
// fill, and in_ready drops once the queue is full; it rises again in the cycle
// after the stalled result is taken. Reset clears all key, level and flag state
// and loads the register defaults. The user must write registers over APB only
// while no word is in flight, which the block leaves unchecked; writing
// volume_start or brightness_start also loads the current level.
// ----------------------------------------------------------------------------
module key_repeat_level_control
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  krl_pkg::krl_in_t  in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output krl_pkg::krl_out_t out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import krl_pkg::*;

    logic [15:0] hold_delay_reg;
    logic [15:0] repeat_interval_reg;
    logic [15:0] stale_limit_reg;
    logic [4:0]  vol_limit_reg;
    logic [3:0]  bri_limit_reg;
    logic [4:0]  volume_start_reg;
    logic [3:0]  brightness_start_reg;

    logic        wr_en;
    logic [2:0]  reg_index;
    krl_cfg_t    cfg;
    krl_load_t   load;

    logic        push;
    krl_cmd_t    front_cmd;
    logic        queue_full;
    logic        queue_valid;
    logic        pop;
    krl_cmd_t    queue_cmd;
    logic        snap_valid;
    logic        snap_ready;
    krl_snap_t   snap;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign reg_index = paddr[4:2];

    assign cfg.hold_delay      = hold_delay_reg;
    assign cfg.repeat_interval = repeat_interval_reg;
    assign cfg.stale_limit     = stale_limit_reg;
    assign cfg.vol_limit       = vol_limit_reg;
    assign cfg.bri_limit       = bri_limit_reg;

    assign load.vol_load = wr_en && reg_index == REG_VOLUME_START;
    assign load.bri_load = wr_en && reg_index == REG_BRIGHTNESS_START;
    assign load.vol_val  = pwdata[4:0];
    assign load.bri_val  = pwdata[3:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_delay_reg       <= HOLD_DELAY_RST;
            repeat_interval_reg  <= REPEAT_INTERVAL_RST;
            stale_limit_reg      <= STALE_LIMIT_RST;
            vol_limit_reg        <= VOL_LIMIT_RST;
            bri_limit_reg        <= BRI_LIMIT_RST;
            volume_start_reg     <= '0;
            brightness_start_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_HOLD_DELAY:       hold_delay_reg       <= pwdata[15:0];
                REG_REPEAT_INTERVAL:  repeat_interval_reg  <= pwdata[15:0];
                REG_STALE_LIMIT:      stale_limit_reg      <= pwdata[15:0];
                REG_VOL_LIMIT:        vol_limit_reg        <= pwdata[4:0];
                REG_BRI_LIMIT:        bri_limit_reg        <= pwdata[3:0];
                REG_VOLUME_START:     volume_start_reg     <= pwdata[4:0];
                REG_BRIGHTNESS_START: brightness_start_reg <= pwdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_HOLD_DELAY:       prdata = {16'd0, hold_delay_reg};
            REG_REPEAT_INTERVAL:  prdata = {16'd0, repeat_interval_reg};
            REG_STALE_LIMIT:      prdata = {16'd0, stale_limit_reg};
            REG_VOL_LIMIT:        prdata = {27'd0, vol_limit_reg};
            REG_BRI_LIMIT:        prdata = {28'd0, bri_limit_reg};
            REG_VOLUME_START:     prdata = {27'd0, volume_start_reg};
            REG_BRIGHTNESS_START: prdata = {28'd0, brightness_start_reg};
            default:              prdata = '0;
        endcase
    end

    krl_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (front_cmd)
    );

    krl_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (pop),
        .valid     (queue_valid),
        .pop_data  (queue_cmd)
    );

    krl_exec u_exec
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (queue_valid),
        .cmd        (queue_cmd),
        .pop        (pop),
        .cfg        (cfg),
        .load       (load),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready)
    );

    krl_report u_report
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

### rtl/core/krl_checker.sv
// ----------------------------------------------------------------------------
// krl_checker
// Port-level checks of the key repeat level control, bound to the top level.
// ----------------------------------------------------------------------------
`include "key_repeat_level_control_assert.svh"

module krl_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  krl_pkg::krl_out_t out_item
);
    import krl_pkg::*;

    // a stalled result holds its word
    `KRL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

    // nothing comes out right after reset
    `KRL_ASSERT_IMPLY(a_reset_empty, $rose(rst_n), !out_valid)

    // wake delay is capped and only reported while a key repeats
    `KRL_ASSERT_IMPLY(a_wake_range, out_valid,
        out_item.wake_in_ms <= WAKE_CAP_MS && (out_item.repeat_armed || out_item.wake_in_ms == 7'd0))

    // input backpressure only comes from a stalled output
    `KRL_ASSERT_IMPLY(a_backpressure, !in_ready, out_valid)

endmodule

bind key_repeat_level_control krl_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

### tb/sv/tb_key_repeat_level_control.sv
// ----------------------------------------------------------------------------
// tb_key_repeat_level_control
// Self-checking bench for the key repeat level control.
// A short stimulus table (reset state, key and switch handling, stale events,
// wake gaps, time wrap) runs first. It is followed by register phases, the
// extreme settings among them, each with random wake rounds and some noise.
// Every accepted word is run through a local level predictor. Each result
// word is compared field by field with the oldest prediction or table value.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_key_repeat_level_control;

    timeunit 1ns;
    timeprecision 1ps;

    import krl_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [2:0] REG_UNUSED  = 3'd7;

    typedef struct {
        krl_in_t  word;
        bit       typed;
        krl_out_t want;
    } plan_row_t;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    krl_in_t     in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    krl_out_t    out_item;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the registers and the key state
    logic [15:0] hold_ms;
    logic [15:0] interval_ms;
    logic [15:0] stale_ms;
    logic [4:0]  vol_ceiling;
    logic [3:0]  bri_ceiling;
    logic        menu_on;
    logic        plus_on;
    logic        plus_first;
    logic        minus_on;
    logic        minus_first;
    logic [31:0] plus_due;
    logic [31:0] minus_due;
    logic [31:0] wake_ms;
    logic [31:0] prev_wake_ms;
    logic [4:0]  vol_now;
    logic [3:0]  bri_now;
    logic        mute_on;
    logic        jack_on;

    krl_out_t    reports_due[$];
    plan_row_t   plan[$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          hold_left  = 0;
    bit          in_calm    = 1'b0;
    bit          out_calm   = 1'b0;
    logic [31:0] clock_ms   = '0;

    key_repeat_level_control dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #4 clk = ~clk;
    end

    function automatic krl_in_t mk_word(input logic [1:0] kind, input logic [31:0] now,
                                        input logic [15:0] etype, input logic [9:0] code,
                                        input logic [7:0] val, input logic [31:0] ems);
        krl_in_t w;
        w.kind        = kind;
        w.now_ms      = now;
        w.event_type  = etype;
        w.event_code  = code;
        w.event_value = val;
        w.event_ms    = ems;
        return w;
    endfunction

    function automatic void plan_row(input krl_in_t w, input bit typed, input krl_out_t want);
        plan_row_t row;
        row.word  = w;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void nudge_level(input logic up);
        if (menu_on)
        begin
            if (up)
            begin
                if (bri_now < bri_ceiling)
                    bri_now = bri_now + 4'd1;
            end
            else if (bri_now != 4'd0)
                bri_now = bri_now - 4'd1;
        end
        else
        begin
            if (up)
            begin
                if (vol_now < vol_ceiling)
                    vol_now = vol_now + 5'd1;
            end
            else if (vol_now != 5'd0)
                vol_now = vol_now - 5'd1;
        end
    endfunction

    function automatic void load_setting(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            REG_HOLD_DELAY:       hold_ms     = value[15:0];
            REG_REPEAT_INTERVAL:  interval_ms = value[15:0];
            REG_STALE_LIMIT:      stale_ms    = value[15:0];
            REG_VOL_LIMIT:        vol_ceiling = value[4:0];
            REG_BRI_LIMIT:        bri_ceiling = value[3:0];
            REG_VOLUME_START:     vol_now     = value[4:0];
            REG_BRIGHTNESS_START: bri_now     = value[3:0];
            default: ;
        endcase
    endfunction

    // applies one word to the predicted state and returns the report it causes
    function automatic krl_out_t advance_levels(input krl_in_t w);
        krl_out_t    r;
        logic        on;
        logic [31:0] due;
        logic [31:0] gap;
        on  = (w.event_value != 8'd0);
        gap = '0;
        case (w.kind)
            KIND_WAKE_START:
            begin
                wake_ms = w.now_ms;
                if (wake_ms - prev_wake_ms > 32'(stale_ms))
                begin
                    menu_on     = 1'b0;
                    plus_on     = 1'b0;
                    plus_first  = 1'b0;
                    minus_on    = 1'b0;
                    minus_first = 1'b0;
                    plus_due    = '0;
                    minus_due   = '0;
                end
            end
            KIND_EVENT:
            begin
                // stale events are dropped whole
                if (wake_ms - w.event_ms <= 32'(stale_ms))
                begin
                    if (w.event_type == EVT_SWITCH)
                    begin
                        if (w.event_code == SWITCH_JACK)
                            jack_on = on;
                        else if (w.event_code == SWITCH_MUTE)
                            mute_on = on;
                    end
                    else if (w.event_type == EVT_KEY && w.event_value <= KEY_VAL_MAX)
                    begin
                        if (w.event_code == KEY_MENU_A || w.event_code == KEY_MENU_B ||
                            w.event_code == KEY_MENU_C)
                            menu_on = on;
                        else if (w.event_code == KEY_PLUS)
                        begin
                            plus_on    = on;
                            plus_first = on;
                            if (on)
                                plus_due = wake_ms + 32'(hold_ms);
                        end
                        else if (w.event_code == KEY_MINUS)
                        begin
                            minus_on    = on;
                            minus_first = on;
                            if (on)
                                minus_due = wake_ms + 32'(hold_ms);
                        end
                    end
                end
            end
            KIND_WAKE_END:
            begin
                // a fresh press steps once without moving the deadline
                if (plus_first || (plus_on && wake_ms >= plus_due))
                begin
                    nudge_level(1'b1);
                    if (plus_first)
                        plus_first = 1'b0;
                    else
                        plus_due = plus_due + 32'(interval_ms);
                end
                if (minus_first || (minus_on && wake_ms >= minus_due))
                begin
                    nudge_level(1'b0);
                    if (minus_first)
                        minus_first = 1'b0;
                    else
                        minus_due = minus_due + 32'(interval_ms);
                end
                prev_wake_ms = wake_ms;
            end
            default: ;
        endcase

        if (plus_on || minus_on)
        begin
            due = plus_on ? plus_due : minus_due;
            if (minus_on && (!plus_on || minus_due < due))
                due = minus_due;
            gap = (due > wake_ms) ? due - wake_ms : 32'd0;
            if (gap > 32'(WAKE_CAP_MS))
                gap = 32'(WAKE_CAP_MS);
        end
        r.volume       = vol_now;
        r.brightness   = bri_now;
        r.mute         = mute_on;
        r.jack         = jack_on;
        r.repeat_armed = plus_on || minus_on;
        r.wake_in_ms   = gap[6:0];
        return r;
    endfunction

    function automatic krl_in_t random_event(input logic [31:0] now);
        int          r;
        logic [15:0] etype;
        logic [9:0]  code;
        logic [7:0]  val;
        logic [31:0] age;
        r = $urandom_range(0, 99);
        if (r < 70)
            etype = EVT_KEY;
        else if (r < 88)
            etype = EVT_SWITCH;
        else
            etype = 16'($urandom());
        r = $urandom_range(0, 99);
        if (etype == EVT_SWITCH)
            code = (r < 45) ? SWITCH_MUTE : (r < 90) ? SWITCH_JACK : 10'($urandom());
        else if (r < 35)
            code = KEY_PLUS;
        else if (r < 70)
            code = KEY_MINUS;
        else if (r < 78)
            code = KEY_MENU_A;
        else if (r < 84)
            code = KEY_MENU_B;
        else if (r < 90)
            code = KEY_MENU_C;
        else
            code = 10'($urandom());
        r = $urandom_range(0, 99);
        if (r < 40)
            val = 8'd1;
        else if (r < 75)
            val = 8'd0;
        else if (r < 88)
            val = KEY_VAL_MAX;
        else
            val = 8'($urandom());
        r = $urandom_range(0, 99);
        if (r < 85)
            age = 32'($urandom_range(0, (stale_ms < 16'd300) ? int'(stale_ms) : 300));
        else if (r < 95)
            age = 32'(stale_ms) + 32'($urandom_range(1, 100));
        else
            age = $urandom();
        return mk_word(KIND_EVENT, $urandom(), etype, code, val, now - age);
    endfunction

    // valid stays up after acceptance until the next word or settle() drops it
    task automatic push_word(input krl_in_t w, input bit typed, input krl_out_t want);
        int       idle;
        krl_out_t calc;
        idle = pick_gap(in_calm);
        @(negedge clk);
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= w;
        do @(posedge clk); while (!in_ready);
        calc = advance_levels(w);
        reports_due.push_back(typed ? want : calc);
        words_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        load_setting(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wake_round();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 88)
            clock_ms = clock_ms + 32'($urandom_range(0, 160));
        else if (r < 97)
            clock_ms = clock_ms + 32'(stale_ms) + 32'($urandom_range(1, 200));
        else
            clock_ms = $urandom();
        push_word(mk_word(KIND_WAKE_START, clock_ms, 16'($urandom()), 10'($urandom()),
                          8'($urandom()), $urandom()), 1'b0, '0);
        n = $urandom_range(0, 3);
        repeat (n)
            push_word(random_event(clock_ms), 1'b0, '0);
        push_word(mk_word(KIND_WAKE_END, $urandom(), 16'($urandom()), 10'($urandom()),
                          8'($urandom()), $urandom()), 1'b0, '0);
    endtask

    task automatic random_phase(input int words);
        int first;
        int drain_at;
        bit drained;
        first    = words_sent;
        drain_at = $urandom_range(10, words - 10);
        drained  = 1'b0;
        clock_ms = $urandom();
        while (words_sent - first < words)
        begin
            // hold off once mid-phase until every report is back
            if (!drained && words_sent - first >= drain_at)
            begin
                settle();
                drained = 1'b1;
            end
            if ($urandom_range(0, 99) < 85)
                wake_round();
            else
                push_word(mk_word(2'($urandom()), $urandom(), 16'($urandom()),
                                  10'($urandom()), 8'($urandom()),
                                  clock_ms - 32'($urandom_range(0, 50))), 1'b0, '0);
        end
    endtask

    task automatic check_report(input krl_out_t want, input krl_out_t got);
        if (got.volume != want.volume)
        begin
            $display("%0t: volume expected %0d got %0d", $time, want.volume, got.volume);
            mismatches++;
        end
        if (got.brightness != want.brightness)
        begin
            $display("%0t: brightness expected %0d got %0d", $time, want.brightness,
                     got.brightness);
            mismatches++;
        end
        if (got.mute !== want.mute)
        begin
            $display("%0t: mute expected %0b got %0b", $time, want.mute, got.mute);
            mismatches++;
        end
        if (got.jack !== want.jack)
        begin
            $display("%0t: jack expected %0b got %0b", $time, want.jack, got.jack);
            mismatches++;
        end
        if (got.repeat_armed !== want.repeat_armed)
        begin
            $display("%0t: repeat_armed expected %0b got %0b", $time, want.repeat_armed,
                     got.repeat_armed);
            mismatches++;
        end
        if (got.wake_in_ms != want.wake_in_ms)
        begin
            $display("%0t: wake_in_ms expected %0d got %0d", $time, want.wake_in_ms,
                     got.wake_in_ms);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (reports_due.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none got %h", $time,
                         out_item);
                mismatches++;
            end
            else
                check_report(reports_due.pop_front(), out_item);
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            hold_left = pick_gap(out_calm);
        end
    end

    initial
    begin
        #5_000_000;
        $display("key_repeat_level_control verification failed");
        $finish;
    end

    initial
    begin
        hold_ms      = HOLD_DELAY_RST;
        interval_ms  = REPEAT_INTERVAL_RST;
        stale_ms     = STALE_LIMIT_RST;
        vol_ceiling  = VOL_LIMIT_RST;
        bri_ceiling  = BRI_LIMIT_RST;
        menu_on      = 1'b0;
        plus_on      = 1'b0;
        plus_first   = 1'b0;
        minus_on     = 1'b0;
        minus_first  = 1'b0;
        plus_due     = '0;
        minus_due    = '0;
        wake_ms      = '0;
        prev_wake_ms = '0;
        vol_now      = '0;
        bri_now      = '0;
        mute_on      = 1'b0;
        jack_on      = 1'b0;

        // report = {volume, brightness, mute, jack, armed, wake_in_ms}
        plan_row(mk_word(KIND_WAKE_START, 32'd0, 16'd0, 10'd0, 8'd0, 32'd0),
                 1'b1, {5'd0, 4'd0, 1'b0, 1'b0, 1'b0, 7'd0});
        plan_row(mk_word(KIND_EVENT, 32'd0, EVT_KEY, KEY_PLUS, 8'd1, 32'd0),
                 1'b1, {5'd0, 4'd0, 1'b0, 1'b0, 1'b1, 7'd100});
        plan_row(mk_word(KIND_WAKE_END, 32'd0, 16'd0, 10'd0, 8'd0, 32'd0),
                 1'b1, {5'd1, 4'd0, 1'b0, 1'b0, 1'b1, 7'd100});
        plan_row(mk_word(KIND_WAKE_START, 32'd350, 16'd0, 10'd0, 8'd0, 32'd0),
                 1'b1, {5'd1, 4'd0, 1'b0, 1'b0, 1'b1, 7'd0});
        plan_row(mk_word(KIND_WAKE_END, 32'd0, 16'd0, 10'd0, 8'd0, 32'd0),
                 1'b1, {5'd2, 4'd0, 1'b0, 1'b0, 1'b1, 7'd50});
        plan_row(mk_word(KIND_EVENT, 32'd0, EVT_SWITCH, SWITCH_MUTE, 8'd255, 32'd350),
                 1'b1, {5'd2, 4'd0, 1'b1, 1'b0, 1'b1, 7'd50});
        plan_row(mk_word(KIND_EVENT, 32'd0, EVT_SWITCH, SWITCH_JACK, 8'd1, 32'd350),
                 1'b1, {5'd2, 4'd0, 1'b1, 1'b1, 1'b1, 7'd50});
        // unknown switch code
        plan_row(mk_word(KIND_EVENT, 32'd0, EVT_SWITCH, 10'd3, 8'd1, 32'd350), 1'b0, '0);
        // repeat value counts as held
        plan_row(mk_word(KIND_EVENT, 32'd0, EVT_KEY, KEY_MENU_B, KEY_VAL_MAX, 32'd340),
                 1'b0, '0);
        plan_row(mk_word(KIND_EVENT, 32'd0, EVT_KEY, KEY_MINUS, 8'd1, 32'd350), 1'b0, '0);
        plan_row(mk_word(KIND_WAKE_END, 32'd0, 16'd0, 10'd0, 8'd0, 32'd0), 1'b0, '0);
        plan_row(mk_word(KIND_EVENT, 32'd0, EVT_KEY, KEY_PLUS, 8'd3, 32'd350), 1'b0, '0);
        plan_row(mk_word(KIND_EVENT, 32'd0, 16'd7, KEY_PLUS, 8'd1, 32'd350), 1'b0, '0);
        // one ms past the age limit
        plan_row(mk_word(KIND_EVENT, 32'd0, EVT_KEY, KEY_MENU_A, 8'd0, 32'd350 - 32'd1001),
                 1'b0, '0);
        plan_row(mk_word(KIND_EVENT, 32'd0, EVT_KEY, KEY_MENU_C, 8'd0, 32'd350), 1'b0, '0);
        plan_row(mk_word(KIND_EVENT, 32'd0, EVT_KEY, KEY_PLUS, 8'd0, 32'd350), 1'b0, '0);
        plan_row(mk_word(KIND_EVENT, 32'd0, EVT_SWITCH, SWITCH_MUTE, 8'd0, 32'd350),
                 1'b0, '0);
        plan_row(mk_word(KIND_UNUSED, '1, '1, '1, '1, '1), 1'b0, '0);
        // wake gap one past the limit clears held keys
        plan_row(mk_word(KIND_WAKE_START, 32'd1351, 16'd0, 10'd0, 8'd0, 32'd0), 1'b0, '0);
        plan_row(mk_word(KIND_WAKE_START, 32'hFFFF_FFFF, 16'd0, 10'd0, 8'd0, 32'd0),
                 1'b0, '0);
        // deadline wraps past zero
        plan_row(mk_word(KIND_EVENT, 32'd0, EVT_KEY, KEY_PLUS, 8'd1, 32'hFFFF_FFF0),
                 1'b0, '0);
        // timestamp ahead of the wake time looks ancient
        plan_row(mk_word(KIND_EVENT, 32'd0, EVT_KEY, KEY_MINUS, 8'd1, 32'd0), 1'b0, '0);
        plan_row(mk_word(KIND_WAKE_END, 32'd0, 16'd0, 10'd0, 8'd0, 32'd0), 1'b0, '0);
        plan_row(mk_word(KIND_WAKE_END, '1, '1, '1, '1, '1), 1'b0, '0);
        plan_row(mk_word(KIND_EVENT, 32'd0, 16'hFFFF, 10'h3FF, 8'd0, 32'hFFFF_FFFF),
                 1'b0, '0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            push_word(plan[i].word, plan[i].typed, plan[i].want);

        for (int p = 1; p <= 6; p++)
        begin
            settle();
            in_calm  = ($urandom_range(0, 3) == 0) || (p == 1);
            out_calm = ($urandom_range(0, 3) == 0) || (p == 1);
            case (p)
                1:
                begin
                    write_reg(REG_HOLD_DELAY, 32'd0);
                    write_reg(REG_REPEAT_INTERVAL, 32'd0);
                    write_reg(REG_STALE_LIMIT, 32'd65535);
                    write_reg(REG_VOL_LIMIT, 32'd31);
                    write_reg(REG_BRI_LIMIT, 32'd15);
                    write_reg(REG_VOLUME_START, 32'd0);
                    write_reg(REG_BRIGHTNESS_START, 32'd15);
                    write_reg(REG_UNUSED, $urandom());
                end
                2:
                begin
                    write_reg(REG_HOLD_DELAY, 32'd65535);
                    write_reg(REG_REPEAT_INTERVAL, 32'd65535);
                    write_reg(REG_STALE_LIMIT, 32'd0);
                    write_reg(REG_VOL_LIMIT, 32'd0);
                    write_reg(REG_BRI_LIMIT, 32'd0);
                    // start levels above the ceilings
                    write_reg(REG_VOLUME_START, 32'd31);
                    write_reg(REG_BRIGHTNESS_START, 32'd15);
                end
                default:
                begin
                    // upper bits carry junk the register must drop
                    write_reg(REG_HOLD_DELAY,
                              {16'($urandom()), 16'($urandom_range(0, 500))});
                    write_reg(REG_REPEAT_INTERVAL,
                              {16'($urandom()), 16'($urandom_range(0, 200))});
                    write_reg(REG_STALE_LIMIT,
                              {16'($urandom()), 16'($urandom_range(50, 1500))});
                    write_reg(REG_VOL_LIMIT, $urandom());
                    write_reg(REG_BRI_LIMIT, $urandom());
                    write_reg(REG_VOLUME_START, $urandom());
                    write_reg(REG_BRIGHTNESS_START, $urandom());
                end
            endcase
            random_phase(62);
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("key_repeat_level_control verification clean");
        else
            $display("key_repeat_level_control verification failed");
        $finish;
    end

endmodule
